/* design/sse_pkg.sv */
// sparse set engine package: field widths, command and status codes,
// default sizes shared by the ram and the top level; no dependencies
`timescale 1ns / 1ps

package sse_pkg;

	localparam int MAX_IDS_DEF    = 1024;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int CMD_W     = 2;
	localparam int IDENT_W   = 10;
	localparam int PAYLOAD_W = 32;
	localparam int STATUS_W  = 2;
	localparam int RDATA_W   = 32;
	localparam int COUNT_W   = 11;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_GET    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE      = 2'd0,
		STAT_ABSENT    = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_OVERWRITE = 2'd3
	} status_t;

endpackage

/* design/sse_ram.sv */
// single-port-write, single-port-read synchronous ram with registered read data
// depends on sse_pkg for default sizes
`timescale 1ns / 1ps

module sse_ram #(
	parameter int DEPTH = sse_pkg::MAX_IDS_DEF,
	parameter int WIDTH = sse_pkg::DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/sparse_set_engine.sv */
// sparse set engine top level: command sequencer around the id map ram and the dense ram
// depends on sse_pkg and sse_ram
`timescale 1ns / 1ps

// Keeps a set of up to MAX_IDS ids, each with one data word, as a sparse map
// (id to slot, with a valid bit) and a dense store (slot to id and data word).
// Commands arrive on s_axis_tuser, one result beat leaves per command beat.
// After reset the map ram is swept empty, one entry per cycle, over all MAX_IDS
// entries; no command beat is taken during that pass. Items are handled one at
// a time: add, absent-id answers and the no-op command go from acceptance via
// ST_EXEC to the result register; get and remove also pass ST_GET or ST_REM, as
// get needs a dependent dense read after the map read and remove needs two
// writes into the map ram, which has a single write port. The next beat is taken
// in the cycle after the result is registered, even while that result waits.
module sparse_set_engine #(
	parameter int MAX_IDS    = sse_pkg::MAX_IDS_DEF,
	parameter int DATA_WIDTH = sse_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// ident [9:0], payload [41:10], zero fill
	input  logic [sse_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// cmd [1:0]
	input  logic [sse_pkg::CMD_W-1:0]     s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// read_data [31:0], live_count [42:32], zero fill
	output logic [sse_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// status [1:0]
	output logic [sse_pkg::STATUS_W-1:0]  m_axis_tuser
);

	localparam int IW      = $clog2(MAX_IDS);
	localparam int CW      = $clog2(MAX_IDS + 1);
	localparam int MAP_W   = IW + 1;
	localparam int DENSE_W = IW + DATA_WIDTH;
	localparam int IDW     = sse_pkg::IDENT_W;
	localparam int PLW     = sse_pkg::PAYLOAD_W;
	localparam int OCW     = sse_pkg::COUNT_W;
	localparam int ORW     = sse_pkg::RDATA_W;
	localparam int OPAD    = sse_pkg::M_TDATA_W - OCW - ORW;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_EXEC  = 5'b00100,
		ST_GET   = 5'b01000,
		ST_REM   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [IW-1:0] clr_q;
	logic [CW-1:0] count_q, count_d;

	sse_pkg::cmd_t    cmd_q;
	logic [IW-1:0]    idx_q;
	logic             ok_q;
	logic [DATA_WIDTH-1:0] word_q;

	logic                m_valid_q;
	sse_pkg::status_t    out_status_q;
	logic [ORW-1:0]      out_rdata_q;
	logic [OCW-1:0]      out_count_q;

	logic [IDW-1:0] in_ident;
	logic [PLW-1:0] in_payload;
	logic [31:0]    in_ident_ext;
	logic           accept;
	logic           out_free;

	logic               map_we, map_re;
	logic [IW-1:0]      map_wa, map_ra;
	logic [MAP_W-1:0]   map_wd, map_rd;
	logic               dense_we, dense_re;
	logic [IW-1:0]      dense_wa, dense_ra;
	logic [DENSE_W-1:0] dense_wd, dense_rd;

	logic                  mv;
	logic [IW-1:0]         ms;
	logic [CW-1:0]         last;
	logic [IW-1:0]         moved;
	logic [DATA_WIDTH-1:0] dense_data;

	logic             out_load;
	sse_pkg::status_t out_status;
	logic [ORW-1:0]   out_rdata;

	assign in_ident     = s_axis_tdata[IDW-1:0];
	assign in_payload   = s_axis_tdata[IDW+PLW-1:IDW];
	assign in_ident_ext = 32'(in_ident);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept       = s_axis_tvalid && s_axis_tready;
	assign out_free     = !m_valid_q || m_axis_tready;

	assign mv         = map_rd[IW];
	assign ms         = map_rd[IW-1:0];
	assign last       = count_q - CW'(1);
	assign moved      = dense_rd[DENSE_W-1:DATA_WIDTH];
	assign dense_data = dense_rd[DATA_WIDTH-1:0];

	sse_ram #(.DEPTH(MAX_IDS), .WIDTH(MAP_W)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_wa),
		.wdata (map_wd),
		.re    (map_re),
		.raddr (map_ra),
		.rdata (map_rd)
	);

	sse_ram #(.DEPTH(MAX_IDS), .WIDTH(DENSE_W)) u_dense_ram (
		.clk   (clk),
		.we    (dense_we),
		.waddr (dense_wa),
		.wdata (dense_wd),
		.re    (dense_re),
		.raddr (dense_ra),
		.rdata (dense_rd)
	);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		map_we     = 1'b0;
		map_wa     = idx_q;
		map_wd     = '0;
		map_re     = accept;
		map_ra     = in_ident_ext[IW-1:0];
		dense_we   = 1'b0;
		dense_wa   = ms;
		dense_wd   = {idx_q, word_q};
		dense_re   = accept;
		dense_ra   = last[IW-1:0];
		out_load   = 1'b0;
		out_status = sse_pkg::STAT_DONE;
		out_rdata  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q;
				map_wd = '0;
				if (clr_q == IW'(MAX_IDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					priority if (cmd_q == sse_pkg::CMD_NOP) begin
						out_status = sse_pkg::STAT_DONE;
					end else if (!ok_q) begin
						out_status = sse_pkg::STAT_ABSENT;
					end else if (cmd_q == sse_pkg::CMD_ADD) begin
						priority if (mv) begin
							dense_we   = 1'b1;
							dense_wa   = ms;
							out_status = sse_pkg::STAT_OVERWRITE;
						end else if (count_q >= CW'(MAX_IDS)) begin
							out_status = sse_pkg::STAT_FULL;
						end else begin
							map_we     = 1'b1;
							map_wa     = idx_q;
							map_wd     = {1'b1, count_q[IW-1:0]};
							dense_we   = 1'b1;
							dense_wa   = count_q[IW-1:0];
							count_d    = count_q + CW'(1);
							out_status = sse_pkg::STAT_DONE;
						end
					end else if (cmd_q == sse_pkg::CMD_GET) begin
						if (mv) begin
							out_load = 1'b0;
							dense_re = 1'b1;
							dense_ra = ms;
							state_d  = ST_GET;
						end else begin
							out_status = sse_pkg::STAT_ABSENT;
						end
					end else begin
						if (!mv || count_q == '0) begin
							out_status = sse_pkg::STAT_ABSENT;
						end else begin
							out_load = 1'b0;
							state_d  = ST_REM;
							if (CW'(ms) < last) begin
								dense_we = 1'b1;
								dense_wa = ms;
								dense_wd = dense_rd;
								map_we   = 1'b1;
								map_wa   = moved;
								map_wd   = {1'b1, ms};
							end
						end
					end
				end
			end
			ST_GET: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_status = sse_pkg::STAT_DONE;
					out_rdata  = ORW'(dense_data);
					state_d    = ST_IDLE;
				end
			end
			ST_REM: begin
				if (out_free) begin
					map_we     = 1'b1;
					map_wa     = idx_q;
					map_wd     = '0;
					count_d    = last;
					out_load   = 1'b1;
					out_status = sse_pkg::STAT_DONE;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= sse_pkg::cmd_t'(s_axis_tuser);
			idx_q  <= in_ident_ext[IW-1:0];
			ok_q   <= (in_ident_ext < 32'(MAX_IDS));
			word_q <= DATA_WIDTH'(in_payload);
		end
		if (out_load) begin
			out_status_q <= out_status;
			out_rdata_q  <= out_rdata;
			out_count_q  <= OCW'(count_d);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{OPAD{1'b0}}, out_count_q, out_rdata_q};
	assign m_axis_tuser  = out_status_q;

endmodule

/* tb/sse_set_checker.sv */
// scoreboard for the sparse set engine: mirrors the set from accepted command beats
// and checks every result beat field by field; depends on sse_pkg only
`timescale 1ns / 1ps

module sse_set_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	// ident [9:0], payload [41:10], zero fill
	input  logic [sse_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// cmd [1:0]
	input  logic [sse_pkg::CMD_W-1:0]     s_axis_tuser,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// read_data [31:0], live_count [42:32], zero fill
	input  logic [sse_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// status [1:0]
	input  logic [sse_pkg::STATUS_W-1:0]  m_axis_tuser,
	output int                            mismatches,
	output int                            outstanding
);

	localparam int SET_DEPTH = sse_pkg::MAX_IDS_DEF;
	localparam int IDW       = sse_pkg::IDENT_W;
	localparam int PLW       = sse_pkg::PAYLOAD_W;
	localparam int RDW       = sse_pkg::RDATA_W;
	localparam int CNW       = sse_pkg::COUNT_W;

	typedef struct packed {
		sse_pkg::status_t status;
		logic [RDW-1:0]   read_data;
		logic [CNW-1:0]   live_count;
	} set_result_t;

	logic                 id_used    [SET_DEPTH];
	logic [IDW-1:0]       id_slot    [SET_DEPTH];
	logic [IDW-1:0]       slot_ident [SET_DEPTH];
	logic [RDW-1:0]       slot_word  [SET_DEPTH];
	logic [CNW-1:0]       set_size;
	set_result_t          pending_results[$];
	set_result_t          want;
	set_result_t          got;
	int                   fail_count;

	task automatic apply_set_op(input sse_pkg::cmd_t op, input logic [IDW-1:0] id,
			input logic [PLW-1:0] word, output set_result_t res);
		logic [IDW-1:0] slot;
		logic [CNW-1:0] last;
		res = '0;
		res.status = sse_pkg::STAT_DONE;
		unique case (op)
			sse_pkg::CMD_ADD: begin
				if (id_used[id]) begin
					slot_word[id_slot[id]] = word;
					res.status = sse_pkg::STAT_OVERWRITE;
				end else if (set_size >= SET_DEPTH) begin
					res.status = sse_pkg::STAT_FULL;
				end else begin
					id_used[id] = 1'b1;
					id_slot[id] = set_size[IDW-1:0];
					slot_ident[set_size] = id;
					slot_word[set_size] = word;
					set_size = set_size + 1'b1;
				end
			end
			sse_pkg::CMD_GET: begin
				if (id_used[id])
					res.read_data = slot_word[id_slot[id]];
				else
					res.status = sse_pkg::STAT_ABSENT;
			end
			sse_pkg::CMD_REMOVE: begin
				if (!id_used[id] || set_size == 0) begin
					res.status = sse_pkg::STAT_ABSENT;
				end else begin
					slot = id_slot[id];
					last = set_size - 1'b1;
					// swap the tail element into the freed slot
					if (slot < last) begin
						slot_word[slot] = slot_word[last];
						slot_ident[slot] = slot_ident[last];
						id_slot[slot_ident[last]] = slot;
					end
					id_used[id] = 1'b0;
					id_slot[id] = '0;
					set_size = last;
				end
			end
			default: ;
		endcase
		res.live_count = set_size;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SET_DEPTH; i++) begin
				id_used[i] = 1'b0;
				id_slot[i] = '0;
				slot_ident[i] = '0;
				slot_word[i] = '0;
			end
			set_size = '0;
			pending_results.delete();
			fail_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = sse_pkg::status_t'(m_axis_tuser);
				got.read_data = m_axis_tdata[RDW-1:0];
				got.live_count = m_axis_tdata[RDW +: CNW];
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with none expected, got status %0d",
						$time, got.status);
					$display("%0t: read_data %0h live_count %0d",
						$time, got.read_data, got.live_count);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.status != want.status) begin
						$display("%0t: status expected %0d got %0d", $time,
							want.status, got.status);
						fail_count++;
					end
					if (got.read_data != want.read_data) begin
						$display("%0t: read_data expected %0h got %0h", $time,
							want.read_data, got.read_data);
						fail_count++;
					end
					if (got.live_count != want.live_count) begin
						$display("%0t: live_count expected %0d got %0d", $time,
							want.live_count, got.live_count);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				apply_set_op(sse_pkg::cmd_t'(s_axis_tuser), s_axis_tdata[IDW-1:0],
					s_axis_tdata[IDW +: PLW], want);
				pending_results.push_back(want);
			end
			mismatches <= fail_count;
			outstanding <= pending_results.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// top of the sparse set engine testbench: clock, reset, command stimulus, result back-pressure
// and the verdict; depends on sse_pkg, sparse_set_engine and sse_set_checker
`timescale 1ns / 1ps

module tb_top;

	localparam int SET_CAP = sse_pkg::MAX_IDS_DEF;
	localparam int IDW     = sse_pkg::IDENT_W;
	localparam int PLW     = sse_pkg::PAYLOAD_W;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [sse_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [sse_pkg::CMD_W-1:0]     s_axis_tuser = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [sse_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic [sse_pkg::STATUS_W-1:0]  m_axis_tuser;
	int                            mismatches;
	int                            outstanding;

	int                   snd_idle = 18;
	int                   rcv_idle = 75;
	logic                 hold_go = 1'b0;

	// ids currently in the set, kept only to steer the stimulus
	bit                   member [SET_CAP];
	logic [IDW-1:0]       members[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sparse_set_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	sse_set_checker set_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	function automatic logic [IDW-1:0] absent_id();
		logic [IDW-1:0] id;
		do id = IDW'($urandom_range(SET_CAP - 1)); while (member[id]);
		return id;
	endfunction

	function automatic logic [IDW-1:0] any_member();
		return members[$urandom_range(members.size() - 1)];
	endfunction

	function automatic logic [IDW-1:0] any_id();
		return IDW'($urandom_range(SET_CAP - 1));
	endfunction

	task automatic issue(input sse_pkg::cmd_t op, input logic [IDW-1:0] id,
			input logic [PLW-1:0] word);
		int k;
		k = -1;
		if (op == sse_pkg::CMD_ADD && !member[id] && members.size() < SET_CAP) begin
			member[id] = 1'b1;
			members.push_back(id);
		end else if (op == sse_pkg::CMD_REMOVE && member[id]) begin
			foreach (members[i])
				if (members[i] == id)
					k = i;
			members.delete(k);
			member[id] = 1'b0;
		end
		while ($urandom_range(99) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(sse_pkg::S_TDATA_W - IDW - PLW){1'b0}}, word, id};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic random_item(input int add_w, input int get_w);
		int r;
		logic [PLW-1:0] word;
		r = $urandom_range(99);
		word = $urandom;
		if (r < 3) begin
			issue(sse_pkg::CMD_NOP, any_id(), word);
		end else if (r < 3 + add_w) begin
			if (members.size() < SET_CAP && ($urandom_range(4) != 0 || members.size() == 0))
				issue(sse_pkg::CMD_ADD, absent_id(), word);
			else
				issue(sse_pkg::CMD_ADD, any_member(), word);
		end else if (r < 3 + add_w + get_w) begin
			if (members.size() > 0 && $urandom_range(9) < 7)
				issue(sse_pkg::CMD_GET, any_member(), word);
			else
				issue(sse_pkg::CMD_GET, any_id(), word);
		end else begin
			if (members.size() > 0 && $urandom_range(3) != 0)
				issue(sse_pkg::CMD_REMOVE, any_member(), word);
			else
				issue(sse_pkg::CMD_REMOVE, any_id(), word);
		end
	endtask

	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				hold_left = 300;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty set, extremes of id and payload, overwrite, swap on remove, tail remove
		issue(sse_pkg::CMD_GET, '0, '0);
		issue(sse_pkg::CMD_REMOVE, '0, '1);
		issue(sse_pkg::CMD_NOP, '1, '1);
		issue(sse_pkg::CMD_ADD, '0, '0);
		issue(sse_pkg::CMD_ADD, '1, '1);
		issue(sse_pkg::CMD_ADD, '0, 32'h5a5a_5a5a);
		issue(sse_pkg::CMD_GET, '0, '0);
		issue(sse_pkg::CMD_GET, '1, '0);
		issue(sse_pkg::CMD_ADD, 10'd512, 32'ha5a5_a5a5);
		issue(sse_pkg::CMD_REMOVE, '0, '0);
		issue(sse_pkg::CMD_GET, 10'd512, '0);
		issue(sse_pkg::CMD_GET, '0, '1);
		issue(sse_pkg::CMD_REMOVE, 10'd512, '0);
		issue(sse_pkg::CMD_GET, '1, '0);
		issue(sse_pkg::CMD_REMOVE, '1, '0);
		issue(sse_pkg::CMD_GET, '1, '0);
		issue(sse_pkg::CMD_REMOVE, '1, '0);
		issue(sse_pkg::CMD_ADD, 10'd341, 32'h0000_ffff);
		issue(sse_pkg::CMD_ADD, 10'd682, 32'hffff_0000);
		issue(sse_pkg::CMD_REMOVE, 10'd682, '0);
		issue(sse_pkg::CMD_GET, 10'd682, '0);
		issue(sse_pkg::CMD_GET, 10'd341, '0);

		repeat (250) random_item(50, 25);

		snd_idle = 75;
		rcv_idle <= 18;
		repeat (250) random_item(50, 25);

		// no idling; a long receiver stall while the sender keeps offering beats
		snd_idle = 0;
		rcv_idle <= 0;
		hold_go <= 1'b1;
		repeat (230) random_item(40, 30);

		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
